// ===== src/z80nbr_pkg.sv =====
// ----------------------------------------------------------------------------
// z80nbr_pkg - shared types and constants for the Z80 next-branch resolver
// Opcode constants, decode masks, window geometry and the condition helper.
// ----------------------------------------------------------------------------
package z80nbr_pkg;

	localparam int unsigned WIN_BYTES = 6;
	localparam int unsigned POS_W     = 3;	// prefix count 0..6
	localparam int unsigned IDX_W     = 4;	// byte index up to pos + 2

	// prefixes
	localparam logic [7:0] OP_PFX_IX = 8'hDD;
	localparam logic [7:0] OP_PFX_IY = 8'hFD;
	localparam logic [7:0] OP_PFX_ED = 8'hED;

	// plain opcodes
	localparam logic [7:0] OP_HALT  = 8'h76;
	localparam logic [7:0] OP_RET   = 8'hC9;
	localparam logic [7:0] OP_JP    = 8'hC3;
	localparam logic [7:0] OP_CALL  = 8'hCD;
	localparam logic [7:0] OP_JP_HL = 8'hE9;
	localparam logic [7:0] OP_JR    = 8'h18;
	localparam logic [7:0] OP_DJNZ  = 8'h10;
	localparam logic [7:0] OP_NOP   = 8'h00;
	localparam logic [7:0] OP_EXAF  = 8'h08;

	// masks and patterns
	localparam logic [7:0] MASK_C7     = 8'hC7;
	localparam logic [7:0] MASK_C1     = 8'hC1;
	localparam logic [7:0] MASK_F4     = 8'hF4;
	localparam logic [7:0] PAT_BLOCK   = 8'hB0;
	localparam logic [7:0] PAT_RETX    = 8'h45;
	localparam logic [7:0] PAT_CC      = 8'hC0;
	localparam logic [7:0] PAT_RET_CC  = 8'hC0;
	localparam logic [7:0] PAT_JP_CC   = 8'hC2;
	localparam logic [7:0] PAT_CALL_CC = 8'hC4;
	localparam logic [7:0] PAT_RST     = 8'hC7;
	localparam logic [7:0] PAT_REL     = 8'h00;

	// flag bit positions in F
	localparam int unsigned FLG_S_BIT = 7;
	localparam int unsigned FLG_Z_BIT = 6;
	localparam int unsigned FLG_P_BIT = 2;
	localparam int unsigned FLG_C_BIT = 0;

	typedef enum logic [1:0] {
		BASE_HL,
		BASE_IX,
		BASE_IY
	} base_sel_t;

	typedef struct packed {
		logic taken;
		logic indir;
		logic loop;
		logic call;
		logic blk;
		logic ovf;
	} kind_t;

	// byte of the window, zero past its end
	function automatic logic [7:0] win_byte(input logic [8*WIN_BYTES-1:0] win,
						input logic [IDX_W-1:0] idx);
		logic [7:0] res;
		res = 8'h00;
		for (int i = 0; i < WIN_BYTES; i++) begin
			if (idx == IDX_W'(i)) begin
				res = win[8*i +: 8];
			end
		end
		return res;
	endfunction

	// sel picks Z, C, P/V, S; opcode bit 3 clear means the flag must be clear
	function automatic logic cond_met(input logic [7:0] op, input logic [7:0] f,
					  input logic [1:0] sel);
		logic bit_v;
		unique case (sel)
			2'd0: bit_v = f[FLG_Z_BIT];
			2'd1: bit_v = f[FLG_C_BIT];
			2'd2: bit_v = f[FLG_P_BIT];
			default: bit_v = f[FLG_S_BIT];
		endcase
		return bit_v ^ ~op[3];
	endfunction

endpackage

// ===== src/z80_next_branch_resolver.sv =====
// ----------------------------------------------------------------------------
// z80_next_branch_resolver - next-instruction branch decode for the Z80
// Skips DD/FD/ED prefixes, decodes the opcode and resolves the branch target.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | pc_value, code_window, hl/ix/iy_value,
//          |                    | stack_word, flag_reg, b_value
//  out     | out_valid/out_ready| branch_taken, target_addr, target_indirect,
//          |                    | loop_kind, call_kind, block_kind,
//          |                    | prefix_overflow
//
//  Three register stages: prefix scan, opcode decode, relative-target add.
//  One request per cycle while the output is not stalled.
//  Each stage moves when the one after it is empty or moving, so a stall on
//  out_ready holds each occupied stage in place and backs up to in_ready.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module z80_next_branch_resolver #(
	parameter int MAX_PREFIXES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pc_value,
	input  logic [47:0] code_window,
	input  logic [15:0] hl_value,
	input  logic [15:0] ix_value,
	input  logic [15:0] iy_value,
	input  logic [15:0] stack_word,
	input  logic [7:0]  flag_reg,
	input  logic [7:0]  b_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        branch_taken,
	output logic [15:0] target_addr,
	output logic        target_indirect,
	output logic        loop_kind,
	output logic        call_kind,
	output logic        block_kind,
	output logic        prefix_overflow
);
	import z80nbr_pkg::*;

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	// ---------------- stage 1: prefix scan ----------------
	logic [POS_W-1:0] scan_pos;
	base_sel_t        scan_bsel;
	logic             scan_ext;
	logic [15:0]      scan_base;

	logic [POS_W-1:0] pos_s1;
	logic [7:0]       op_s1, opnd1_s1, opnd2_s1;
	logic [15:0]      base_s1, pc_s1, sw_s1;
	logic [7:0]       f_s1, b_s1;
	logic             ext_s1;

	always_comb begin
		logic       done;
		logic [7:0] byte_v;
		done      = 1'b0;
		scan_pos  = POS_W'(WIN_BYTES);
		scan_bsel = BASE_HL;
		scan_ext  = 1'b0;
		for (int i = 0; i < WIN_BYTES; i++) begin
			byte_v = code_window[8*i +: 8];
			if (!done) begin
				if (byte_v == OP_PFX_IX) begin
					scan_bsel = BASE_IX;
				end else if (byte_v == OP_PFX_IY) begin
					scan_bsel = BASE_IY;
				end else if (byte_v == OP_PFX_ED) begin
					scan_ext = 1'b1;
				end else begin
					scan_pos = POS_W'(i);
					done     = 1'b1;
				end
			end
		end
	end

	always_comb begin
		unique case (scan_bsel)
			BASE_IX: scan_base = ix_value;
			BASE_IY: scan_base = iy_value;
			default: scan_base = hl_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pos_s1   <= scan_pos;
			op_s1    <= win_byte(code_window, IDX_W'(scan_pos));
			opnd1_s1 <= win_byte(code_window, IDX_W'(scan_pos) + IDX_W'(1));
			opnd2_s1 <= win_byte(code_window, IDX_W'(scan_pos) + IDX_W'(2));
			base_s1  <= scan_base;
			ext_s1   <= scan_ext;
			pc_s1    <= pc_value;
			sw_s1    <= stack_word;
			f_s1     <= flag_reg;
			b_s1     <= b_value;
		end
	end

	// ---------------- stage 2: opcode decode ----------------
	logic [1:0]  dec_nops;
	kind_t       dec_kind;
	logic        dec_rel;
	logic [15:0] dec_abs;
	logic [15:0] dec_word;
	logic        pfx_ovf, opnd_ovf;

	kind_t       kind_s2;
	logic        rel_s2;
	logic [15:0] abs_s2, relbase_s2;
	logic [7:0]  disp_s2;

	assign dec_word = {opnd2_s1, opnd1_s1};

	always_comb begin
		dec_nops = 2'd0;
		if (!ext_s1) begin
			if (op_s1 == OP_JP || op_s1 == OP_CALL ||
			    (op_s1 & MASK_C7) == PAT_JP_CC || (op_s1 & MASK_C7) == PAT_CALL_CC) begin
				dec_nops = 2'd2;
			end else if ((op_s1 & MASK_C7) == PAT_REL && op_s1 != OP_NOP &&
				     op_s1 != OP_EXAF) begin
				dec_nops = 2'd1;
			end
		end
	end

	assign pfx_ovf  = (pos_s1 >= POS_W'(WIN_BYTES)) || (int'(pos_s1) > MAX_PREFIXES);
	assign opnd_ovf = (op_s1 != OP_HALT) &&
			  ({1'b0, pos_s1} + 4'd1 + {2'b00, dec_nops} > 4'(WIN_BYTES));

	always_comb begin
		dec_kind = '0;
		dec_rel  = 1'b0;
		dec_abs  = 16'h0000;
		priority if (pfx_ovf || opnd_ovf) begin
			dec_kind.ovf = 1'b1;
		end else if (op_s1 == OP_HALT) begin
			dec_kind.blk = 1'b1;
		end else if (ext_s1) begin
			priority if ((op_s1 & MASK_F4) == PAT_BLOCK) begin
				dec_kind.blk = 1'b1;
			end else if ((op_s1 & MASK_C7) == PAT_RETX) begin
				dec_kind.taken = 1'b1;
				dec_kind.indir = 1'b1;
				dec_abs        = sw_s1;
			end else begin
			end
		end else if (op_s1 == OP_RET) begin
			dec_kind.taken = 1'b1;
			dec_kind.indir = 1'b1;
			dec_abs        = sw_s1;
		end else if (op_s1 == OP_JP) begin
			dec_kind.taken = 1'b1;
			dec_abs        = dec_word;
		end else if (op_s1 == OP_CALL) begin
			dec_kind.taken = 1'b1;
			dec_kind.call  = 1'b1;
			dec_abs        = dec_word;
		end else if ((op_s1 & MASK_C1) == PAT_CC) begin
			if (cond_met(op_s1, f_s1, op_s1[5:4])) begin
				priority if ((op_s1 & MASK_C7) == PAT_RET_CC) begin
					dec_kind.taken = 1'b1;
					dec_kind.indir = 1'b1;
					dec_abs        = sw_s1;
				end else if ((op_s1 & MASK_C7) == PAT_CALL_CC) begin
					dec_kind.taken = 1'b1;
					dec_kind.call  = 1'b1;
					dec_abs        = dec_word;
				end else if ((op_s1 & MASK_C7) == PAT_JP_CC) begin
					dec_kind.taken = 1'b1;
					dec_kind.loop  = 1'b1;
					dec_abs        = dec_word;
				end else begin
				end
			end
		end else if (op_s1 == OP_JP_HL) begin
			dec_kind.taken = 1'b1;
			dec_kind.indir = 1'b1;
			dec_abs        = base_s1;
		end else if ((op_s1 & MASK_C7) == PAT_RST) begin
			dec_kind.taken = 1'b1;
			dec_kind.call  = 1'b1;
			dec_abs        = {10'b0, op_s1[5:3], 3'b000};
		end else if (dec_nops == 2'd1) begin
			priority if (op_s1 == OP_JR) begin
				dec_kind.taken = 1'b1;
				dec_rel        = 1'b1;
			end else if (op_s1 == OP_DJNZ) begin
				if (b_s1 != 8'd1) begin
					dec_kind.taken = 1'b1;
					dec_kind.loop  = 1'b1;
					dec_rel        = 1'b1;
				end
			end else if (cond_met(op_s1, f_s1, {1'b0, op_s1[4]})) begin
				dec_kind.taken = 1'b1;
				dec_kind.loop  = 1'b1;
				dec_rel        = 1'b1;
			end else begin
			end
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			kind_s2    <= dec_kind;
			rel_s2     <= dec_rel;
			abs_s2     <= dec_abs;
			relbase_s2 <= pc_s1 + {13'b0, pos_s1} + 16'd2;
			disp_s2    <= opnd1_s1;
		end
	end

	// ---------------- stage 3: relative add, output register ----------------
	kind_t       kind_s3;
	logic [15:0] target_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			kind_s3   <= kind_s2;
			target_s3 <= rel_s2 ? relbase_s2 + {{8{disp_s2[7]}}, disp_s2} : abs_s2;
		end
	end

	// stage enables: a stage loads when it is empty or its contents move on
	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	assign out_valid       = valid_s3;
	assign branch_taken    = kind_s3.taken;
	assign target_addr     = target_s3;
	assign target_indirect = kind_s3.indir;
	assign loop_kind       = kind_s3.loop;
	assign call_kind       = kind_s3.call;
	assign block_kind      = kind_s3.blk;
	assign prefix_overflow = kind_s3.ovf;

endmodule

// ===== sim/z80nbr_checker.sv =====
// ----------------------------------------------------------------------------
// z80nbr_checker - scoreboard for the Z80 next-branch resolver
// Predicts the branch resolution of every accepted request and compares each
// delivered result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module z80nbr_checker #(
	parameter int MAX_PREFIXES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] pc_value,
	input  logic [47:0] code_window,
	input  logic [15:0] hl_value,
	input  logic [15:0] ix_value,
	input  logic [15:0] iy_value,
	input  logic [15:0] stack_word,
	input  logic [7:0]  flag_reg,
	input  logic [7:0]  b_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        branch_taken,
	input  logic [15:0] target_addr,
	input  logic        target_indirect,
	input  logic        loop_kind,
	input  logic        call_kind,
	input  logic        block_kind,
	input  logic        prefix_overflow,
	output int          mismatch_count,
	output int          open_requests
);
	timeunit 1ns;
	timeprecision 1ps;

	import z80nbr_pkg::*;

	typedef struct packed {
		logic        taken;
		logic [15:0] target;
		logic        indir;
		logic        loop_k;
		logic        call_k;
		logic        blk;
		logic        ovf;
	} branch_res_t;

	branch_res_t resolved_q[$];
	branch_res_t want_r, got_r;
	int errs = 0;

	// window byte, zero beyond the sixth
	function automatic logic [7:0] window_byte(input logic [47:0] win, input int idx);
		if (idx >= WIN_BYTES) begin
			return 8'h00;
		end
		return win[8*idx +: 8];
	endfunction

	// sel: 0 Z, 1 C, 2 P/V, 3 S; opcode bit 3 says whether the flag must be set
	function automatic logic flag_holds(input logic [7:0] op, input logic [7:0] f,
					    input logic [1:0] sel);
		logic v;
		unique case (sel)
			2'd0: v = f[FLG_Z_BIT];
			2'd1: v = f[FLG_C_BIT];
			2'd2: v = f[FLG_P_BIT];
			default: v = f[FLG_S_BIT];
		endcase
		return v == op[3];
	endfunction

	function automatic branch_res_t resolve_branch(input logic [15:0] pc,
						       input logic [47:0] win,
						       input logic [15:0] hl, ix, iy, sw,
						       input logic [7:0] f, b);
		branch_res_t r;
		logic [15:0] base, word, rel;
		logic [7:0]  op, d;
		logic        ext;
		int          pos, nops;
		r    = '0;
		base = hl;
		ext  = 1'b0;
		pos  = 0;
		nops = 0;
		op   = OP_NOP;
		while (pos < WIN_BYTES) begin
			op = win[8*pos +: 8];
			if (op == OP_PFX_IX) base = ix;
			else if (op == OP_PFX_IY) base = iy;
			else if (op == OP_PFX_ED) ext = 1'b1;
			else break;
			pos++;
		end
		if (pos >= WIN_BYTES || pos > MAX_PREFIXES) begin
			r.ovf = 1'b1;
			return r;
		end
		if (!ext) begin
			if (op == OP_JP || op == OP_CALL || (op & MASK_C7) == PAT_JP_CC ||
			    (op & MASK_C7) == PAT_CALL_CC)
				nops = 2;
			else if ((op & MASK_C7) == PAT_REL && op != OP_NOP && op != OP_EXAF)
				nops = 1;
		end
		if (op != OP_HALT && pos + 1 + nops > WIN_BYTES) begin
			r.ovf = 1'b1;
			return r;
		end
		word = {window_byte(win, pos + 2), window_byte(win, pos + 1)};
		d    = window_byte(win, pos + 1);
		rel  = pc + 16'(pos) + 16'd2 + {{8{d[7]}}, d};
		if (op == OP_HALT) begin
			r.blk = 1'b1;
		end else if (ext) begin
			if ((op & MASK_F4) == PAT_BLOCK) begin
				r.blk = 1'b1;
			end else if ((op & MASK_C7) == PAT_RETX) begin
				r.taken = 1'b1; r.indir = 1'b1; r.target = sw;
			end
		end else if (op == OP_RET) begin
			r.taken = 1'b1; r.indir = 1'b1; r.target = sw;
		end else if (op == OP_JP) begin
			r.taken = 1'b1; r.target = word;
		end else if (op == OP_CALL) begin
			r.taken = 1'b1; r.call_k = 1'b1; r.target = word;
		end else if ((op & MASK_C1) == PAT_CC) begin
			if (flag_holds(op, f, op[5:4])) begin
				unique case (op & MASK_C7)
					PAT_RET_CC: begin
						r.taken = 1'b1; r.indir = 1'b1; r.target = sw;
					end
					PAT_CALL_CC: begin
						r.taken = 1'b1; r.call_k = 1'b1; r.target = word;
					end
					PAT_JP_CC: begin
						r.taken = 1'b1; r.loop_k = 1'b1; r.target = word;
					end
					default: ;
				endcase
			end
		end else if (op == OP_JP_HL) begin
			r.taken = 1'b1; r.indir = 1'b1; r.target = base;
		end else if ((op & MASK_C7) == PAT_RST) begin
			r.taken = 1'b1; r.call_k = 1'b1; r.target = {10'b0, op[5:3], 3'b000};
		end else if (nops == 1) begin
			if (op == OP_JR) begin
				r.taken = 1'b1; r.target = rel;
			end else if (op == OP_DJNZ) begin
				// B is decremented first, so B == 1 falls through
				if (b != 8'd1) begin
					r.taken = 1'b1; r.loop_k = 1'b1; r.target = rel;
				end
			end else if (flag_holds(op, f, {1'b0, op[4]})) begin
				r.taken = 1'b1; r.loop_k = 1'b1; r.target = rel;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
				   input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolved_q.delete();
			open_requests <= 0;
		end else begin
			if (in_valid && in_ready)
				resolved_q.push_back(resolve_branch(pc_value, code_window, hl_value,
					ix_value, iy_value, stack_word, flag_reg, b_value));
			if (out_valid && out_ready) begin
				got_r = '{branch_taken, target_addr, target_indirect, loop_kind,
					  call_kind, block_kind, prefix_overflow};
				if (resolved_q.size() == 0) begin
					$display("%0t: result with no request outstanding, expected none, got %p",
						 $time, got_r);
					errs++;
				end else begin
					want_r = resolved_q.pop_front();
					check_field("branch_taken", 16'(want_r.taken), 16'(got_r.taken));
					check_field("target_addr", want_r.target, got_r.target);
					check_field("target_indirect", 16'(want_r.indir), 16'(got_r.indir));
					check_field("loop_kind", 16'(want_r.loop_k), 16'(got_r.loop_k));
					check_field("call_kind", 16'(want_r.call_k), 16'(got_r.call_k));
					check_field("block_kind", 16'(want_r.blk), 16'(got_r.blk));
					check_field("prefix_overflow", 16'(want_r.ovf), 16'(got_r.ovf));
				end
			end
			open_requests <= resolved_q.size();
		end
		mismatch_count <= errs;
	end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb - regression bench for the Z80 next-branch resolver
// Directed opcode and prefix cases, then mostly well-formed random code
// windows under three idling regimes on both handshakes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import z80nbr_pkg::*;

	localparam int PFX_LIMIT   = 3;
	localparam int PHASE_ITEMS = 300;
	localparam int CYCLE_LIMIT = 200000;

	// opcodes not named in the package
	localparam logic [7:0] OP_JR_NZ   = 8'h20;
	localparam logic [7:0] OP_JR_C    = 8'h38;
	localparam logic [7:0] OP_RET_NZ  = 8'hC0;
	localparam logic [7:0] OP_RET_Z   = 8'hC8;
	localparam logic [7:0] OP_JP_PO   = 8'hE2;
	localparam logic [7:0] OP_JP_M    = 8'hFA;
	localparam logic [7:0] OP_CALL_NC = 8'hD4;
	localparam logic [7:0] OP_LDIR    = 8'hB0;
	localparam logic [7:0] OP_RETN    = 8'h45;
	localparam logic [7:0] OP_RETI    = 8'h4D;

	localparam logic [7:0] F_NONE = 8'h00;
	localparam logic [7:0] F_S    = 8'h80;
	localparam logic [7:0] F_Z    = 8'h40;
	localparam logic [7:0] F_C    = 8'h01;

	typedef struct {
		logic [15:0] pc;
		logic [47:0] win;
		logic [15:0] hl, ix, iy, sw;
		logic [7:0]  f, b;
	} fetch_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] pc_value = '0;
	logic [47:0] code_window = '0;
	logic [15:0] hl_value = '0;
	logic [15:0] ix_value = '0;
	logic [15:0] iy_value = '0;
	logic [15:0] stack_word = '0;
	logic [7:0]  flag_reg = '0;
	logic [7:0]  b_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        branch_taken;
	logic [15:0] target_addr;
	logic        target_indirect;
	logic        loop_kind;
	logic        call_kind;
	logic        block_kind;
	logic        prefix_overflow;
	int          mismatch_count;
	int          open_requests;

	int idle_in_pct  = 33;
	int idle_out_pct = 76;
	int cycle_count  = 0;

	z80_next_branch_resolver #(.MAX_PREFIXES(PFX_LIMIT)) uut (.*);
	z80nbr_checker #(.MAX_PREFIXES(PFX_LIMIT)) scoreboard (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= idle_out_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("z80_next_branch_resolver regression: fail");
			$finish;
		end
	end

	function automatic logic [47:0] code_bytes(input logic [7:0] b0, b1, b2, b3, b4, b5);
		return {b5, b4, b3, b2, b1, b0};
	endfunction

	function automatic fetch_req_t directed_req(input logic [15:0] pc, input logic [47:0] win,
						    input logic [7:0] f, b);
		fetch_req_t r;
		r = '{pc, win, 16'h4A51, 16'hB1C3, 16'h7E0F, 16'h8D26, f, b};
		return r;
	endfunction

	function automatic fetch_req_t random_req();
		fetch_req_t r;
		logic [7:0] bytes [6];
		logic [7:0] op;
		int npfx, k, pick;
		for (k = 0; k < 6; k++)
			bytes[k] = 8'($urandom);
		pick = $urandom_range(99);
		npfx = (pick < 45) ? 0 : (pick < 75) ? 1 : (pick < 88) ? 2 :
		       (pick < 94) ? 3 : $urandom_range(6, 4);
		for (k = 0; k < npfx; k++) begin
			pick = $urandom_range(6);
			bytes[k] = (pick < 3) ? OP_PFX_IX : (pick < 6) ? OP_PFX_IY : OP_PFX_ED;
		end
		pick = $urandom_range(15);
		unique case (pick)
			0:  op = OP_JP;
			1:  op = OP_CALL;
			2:  op = OP_RET;
			3:  op = {2'b11, 3'($urandom), 3'b010};
			4:  op = {2'b11, 3'($urandom), 3'b100};
			5:  op = {2'b11, 3'($urandom), 3'b000};
			6:  op = {2'b11, 3'($urandom), 3'b111};
			7:  op = OP_JR;
			8:  op = OP_DJNZ;
			9:  op = {3'b001, 2'($urandom), 3'b000};
			10: op = OP_JP_HL;
			11: op = OP_HALT;
			12: op = {4'b1011, 1'($urandom), 1'b0, 2'($urandom)};
			13: op = {2'b01, 3'($urandom), 3'b101};
			default: op = 8'($urandom);
		endcase
		// extended-page opcodes need an ED somewhere in the chain
		if (pick == 12 || pick == 13) begin
			if (npfx == 0) npfx = 1;
			if (npfx < 6) bytes[$urandom_range(npfx - 1)] = OP_PFX_ED;
		end
		if (npfx < 6) bytes[npfx] = op;
		r.pc  = ($urandom_range(7) == 0) ? 16'hFFF8 + 16'($urandom_range(7)) : 16'($urandom);
		r.win = code_bytes(bytes[0], bytes[1], bytes[2], bytes[3], bytes[4], bytes[5]);
		r.hl  = 16'($urandom);
		r.ix  = 16'($urandom);
		r.iy  = 16'($urandom);
		r.sw  = 16'($urandom);
		r.f   = 8'($urandom);
		pick  = $urandom_range(9);
		r.b   = (pick < 3) ? 8'd1 : (pick == 3) ? 8'd0 : 8'($urandom);
		return r;
	endfunction

	// entered and left on a falling edge
	task automatic send_request(input fetch_req_t r);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		pc_value    <= r.pc;
		code_window <= r.win;
		hl_value    <= r.hl;
		ix_value    <= r.ix;
		iy_value    <= r.iy;
		stack_word  <= r.sw;
		flag_reg    <= r.f;
		b_value     <= r.b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		fetch_req_t ones;
		int n;
		ones = '{'1, '1, '1, '1, '1, '1, '1, '1};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request('{'0, '0, '0, '0, '0, '0, '0, '0});
		send_request(ones);
		send_request(directed_req(16'h0100, code_bytes(OP_JP, 8'h34, 8'h12, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'hFFFD, code_bytes(OP_CALL, 8'hFF, 8'hFF, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h2000, code_bytes(OP_RET, 0, 0, 0, 0, 0), F_NONE, 8'd5));
		send_request(directed_req(16'h2000, code_bytes(OP_RET_NZ, 0, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h2000, code_bytes(OP_RET_Z, 0, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h3000, code_bytes(OP_JP_PO, 8'h00, 8'h80, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h3000, code_bytes(OP_JP_M, 8'hCD, 8'hAB, 0, 0, 0),
					  F_S, 8'd5));
		send_request(directed_req(16'h3000, code_bytes(OP_CALL_NC, 8'h11, 8'h22, 0, 0, 0),
					  F_C, 8'd5));
		// relative targets wrapping both ways
		send_request(directed_req(16'h0000, code_bytes(OP_JR, 8'h80, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'hFFF0, code_bytes(OP_JR_NZ, 8'h7F, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h1234, code_bytes(OP_JR_C, 8'hFE, 0, 0, 0, 0),
					  F_C | F_Z, 8'd5));
		send_request(directed_req(16'h4000, code_bytes(OP_DJNZ, 8'hFC, 0, 0, 0, 0),
					  F_NONE, 8'd1));
		send_request(directed_req(16'h4000, code_bytes(OP_DJNZ, 8'hFC, 0, 0, 0, 0),
					  F_NONE, 8'd0));
		// base selection: last index prefix wins, ED anywhere means extended page
		send_request(directed_req(16'h5000, code_bytes(OP_PFX_IX, OP_JP_HL, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h5000, code_bytes(OP_PFX_IY, OP_JP_HL, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h5000,
			code_bytes(OP_PFX_IX, OP_PFX_IY, OP_JP_HL, 0, 0, 0), F_NONE, 8'd5));
		send_request(directed_req(16'h5000,
			code_bytes(OP_PFX_ED, OP_PFX_IX, OP_JP_HL, 0, 0, 0), F_NONE, 8'd5));
		send_request(directed_req(16'h6000, code_bytes(OP_HALT, 0, 0, 0, 0, 0), F_NONE, 8'd5));
		send_request(directed_req(16'h6000, code_bytes(OP_PFX_ED, OP_HALT, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h6000, code_bytes(OP_PFX_ED, OP_LDIR, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h6000, code_bytes(OP_PFX_ED, OP_RETI, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		send_request(directed_req(16'h6000, code_bytes(OP_PFX_ED, OP_RETN, 0, 0, 0, 0),
					  F_NONE, 8'd5));
		// three prefixes leave exactly room for a jp with its operands
		send_request(directed_req(16'h7000,
			code_bytes(OP_PFX_IX, OP_PFX_IX, OP_PFX_IX, OP_JP, 8'h78, 8'h56), F_NONE, 8'd5));
		send_request(directed_req(16'h7000,
			code_bytes(OP_PFX_IX, OP_PFX_IX, OP_PFX_IY, OP_PFX_ED, OP_JP_HL, 0),
			F_NONE, 8'd5));
		send_request(directed_req(16'h7000, code_bytes(OP_PFX_IX, OP_PFX_IX, OP_PFX_IX,
			OP_PFX_IX, OP_PFX_IX, OP_PFX_IX), F_NONE, 8'd5));

		for (n = 0; n < PHASE_ITEMS; n++)
			send_request(random_req());
		idle_in_pct  = 76;
		idle_out_pct = 33;
		for (n = 0; n < PHASE_ITEMS; n++)
			send_request(random_req());
		idle_in_pct  = 0;
		idle_out_pct = 0;
		for (n = 0; n < PHASE_ITEMS; n++)
			send_request(random_req());
		in_valid <= 1'b0;

		while (open_requests != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("z80_next_branch_resolver regression: pass");
		end else begin
			$display("z80_next_branch_resolver regression: fail");
		end
		$finish;
	end

endmodule
